>>> rtl/quaternion_arithmetic_unit_defines.svh
// assertion macros for the quaternion arithmetic unit
// used by quaternion_arithmetic_unit.sv; expects clk and rst in the including scope
`ifndef QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH
`define QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH

`ifndef SYNTH

// condition holds at every edge out of reset
`define QAU_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define QAU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define QAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define QAU_ASSERT(label, cond, msg)
`define QAU_ASSERT_IMPL(label, ante, cons, msg)
`define QAU_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> rtl/qau_pkg.sv
// shared types, widths and constants for the quaternion arithmetic unit
// no dependencies; imported by qau_lane, qau_merge and the top level
package qau_pkg;

  localparam int FRAC_BITS  = 12;
  localparam int WORD_BITS  = 16;

  localparam int NUM_LANES  = 4;
  localparam int NUM_TERMS  = 4;
  localparam int NUM_TERMS3 = 3;

  // pipeline depth from operand word to result word
  localparam int STAGES     = 5;

  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;
  localparam int LANE_W = 3;

  // sum of four word products
  localparam int SUM_BITS  = 2 * WORD_BITS + 2;
  // rounded sum, also the rotate t term
  localparam int VAL_BITS  = 2 * WORD_BITS - FRAC_BITS + 2;
  // word times t
  localparam int PROD_BITS = WORD_BITS + VAL_BITS;
  // sum of three such products plus the vector term
  localparam int ACC_BITS  = PROD_BITS + 2;
  localparam int FIN_BITS  = ACC_BITS - FRAC_BITS;

  localparam longint WORD_MAX_L = (longint'(1) << (WORD_BITS - 1)) - 1;
  localparam longint WORD_MIN_L = -WORD_MAX_L - 1;

  localparam logic signed [FIN_BITS-1:0]  FIN_MAX  = FIN_BITS'(WORD_MAX_L);
  localparam logic signed [FIN_BITS-1:0]  FIN_MIN  = FIN_BITS'(WORD_MIN_L);
  localparam logic [WORD_BITS-1:0]        WORD_MAX = WORD_BITS'(WORD_MAX_L);
  localparam logic [WORD_BITS-1:0]        WORD_MIN = WORD_BITS'(WORD_MIN_L);

  // 1.0 in the word format, used to pass a component through a multiplier
  localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(longint'(1) << FRAC_BITS);

  localparam logic signed [SUM_BITS:0]   HALF_S = (SUM_BITS+1)'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [ACC_BITS-1:0] HALF_A = ACC_BITS'(longint'(1) << (FRAC_BITS - 1));

  typedef enum logic [2:0] {
    KIND_MUL  = 3'd0,
    KIND_ROT  = 3'd1,
    KIND_CONJ = 3'd2,
    KIND_NEG  = 3'd3,
    KIND_DOT  = 3'd4
  } qau_kind_t;

  typedef struct packed {
    logic [2:0]           kind;
    logic [WORD_BITS-1:0] a_x;
    logic [WORD_BITS-1:0] a_y;
    logic [WORD_BITS-1:0] a_z;
    logic [WORD_BITS-1:0] a_w;
    logic [WORD_BITS-1:0] b_x;
    logic [WORD_BITS-1:0] b_y;
    logic [WORD_BITS-1:0] b_z;
    logic [WORD_BITS-1:0] b_w;
  } qau_op_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] out_x;
    logic [WORD_BITS-1:0] out_y;
    logic [WORD_BITS-1:0] out_z;
    logic [WORD_BITS-1:0] out_w;
    logic                 saturated;
  } qau_res_t;

  // first-pass operands of one lane: four signed products, each optionally negated
  typedef struct packed {
    logic [NUM_TERMS-1:0][WORD_BITS-1:0] ma;
    logic [NUM_TERMS-1:0][WORD_BITS-1:0] mb;
    logic [NUM_TERMS-1:0]                neg;
  } qau_ops1_t;

  // second-pass operands for rotate: word times t, plus the vector component
  typedef struct packed {
    logic [NUM_TERMS3-1:0][WORD_BITS-1:0] qa;
    logic [NUM_TERMS3-1:0][VAL_BITS-1:0]  tb;
    logic [NUM_TERMS3-1:0]                neg;
    logic [WORD_BITS-1:0]                 v;
  } qau_ops3_t;

  // pipeline load enables and rotate flags shared by all lanes
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
    logic rot2;
    logic rot4;
  } qau_ctl_t;

endpackage

>>> rtl/qau_lane.sv
// one result component: products, sum and round, rotate second pass, final sum
// depends on qau_pkg
module qau_lane import qau_pkg::*; (
  input  logic                       clk,
  input  qau_ctl_t                   ctl,
  input  qau_ops1_t                  ops1,
  input  qau_ops3_t                  ops3,
  output logic signed [VAL_BITS-1:0] t,
  output logic signed [FIN_BITS-1:0] fin
);

  logic signed [SUM_BITS-1:0] term1 [NUM_TERMS];
  logic signed [SUM_BITS-1:0] prod1 [NUM_TERMS];
  logic signed [SUM_BITS:0]   sum2;
  logic signed [SUM_BITS:0]   rnd2;

  logic signed [ACC_BITS-1:0] term3 [NUM_TERMS3];
  logic signed [ACC_BITS-1:0] prod3 [NUM_TERMS3];
  logic signed [ACC_BITS-1:0] vsh3;
  logic signed [VAL_BITS-1:0] val3;
  logic signed [ACC_BITS-1:0] acc4;

  always_comb begin
    logic signed [2*WORD_BITS-1:0] raw;
    for (int i = 0; i < NUM_TERMS; i++) begin
      raw      = $signed(ops1.ma[i]) * $signed(ops1.mb[i]);
      term1[i] = ops1.neg[i] ? -SUM_BITS'(raw) : SUM_BITS'(raw);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      for (int i = 0; i < NUM_TERMS; i++) prod1[i] <= term1[i];
    end
  end

  // rotate doubles the cross product before rounding
  always_comb begin
    sum2 = (SUM_BITS+1)'(prod1[0]) + (SUM_BITS+1)'(prod1[1])
         + (SUM_BITS+1)'(prod1[2]) + (SUM_BITS+1)'(prod1[3]);
    if (ctl.rot2) sum2 = sum2 <<< 1;
    rnd2 = (sum2 + HALF_S) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) t <= VAL_BITS'(rnd2);
  end

  always_comb begin
    logic signed [PROD_BITS-1:0] raw;
    for (int i = 0; i < NUM_TERMS3; i++) begin
      raw      = $signed(ops3.qa[i]) * $signed(ops3.tb[i]);
      term3[i] = ops3.neg[i] ? -ACC_BITS'(raw) : ACC_BITS'(raw);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      for (int i = 0; i < NUM_TERMS3; i++) prod3[i] <= term3[i];
      // vector term lifted to the product scale so it rides through the rounding
      vsh3 <= ACC_BITS'($signed(ops3.v)) <<< FRAC_BITS;
      val3 <= t;
    end
  end

  assign acc4 = prod3[0] + prod3[1] + prod3[2] + vsh3 + HALF_A;

  always_ff @(posedge clk) begin
    if (ctl.ld4) fin <= ctl.rot4 ? FIN_BITS'(acc4 >>> FRAC_BITS) : FIN_BITS'(val3);
  end

endmodule

>>> rtl/qau_merge.sv
// merging stage: clips the four lane values to the word and combines the clip flags
// depends on qau_pkg
module qau_merge import qau_pkg::*; (
  input  logic                               clk,
  input  logic                               ld,
  input  logic [NUM_LANES-1:0][FIN_BITS-1:0] fin,
  output qau_res_t                           res
);

  logic [WORD_BITS-1:0] clipped [NUM_LANES];
  logic [NUM_LANES-1:0] clip_hit;
  qau_res_t             res_next;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      if ($signed(fin[i]) > FIN_MAX) begin
        clipped[i]  = WORD_MAX;
        clip_hit[i] = 1'b1;
      end else if ($signed(fin[i]) < FIN_MIN) begin
        clipped[i]  = WORD_MIN;
        clip_hit[i] = 1'b1;
      end else begin
        clipped[i]  = fin[i][WORD_BITS-1:0];
        clip_hit[i] = 1'b0;
      end
    end
    res_next.out_x     = clipped[LANE_X];
    res_next.out_y     = clipped[LANE_Y];
    res_next.out_z     = clipped[LANE_Z];
    res_next.out_w     = clipped[LANE_W];
    res_next.saturated = |clip_hit;
  end

  always_ff @(posedge clk) begin
    if (ld) res <= res_next;
  end

endmodule

>>> rtl/quaternion_arithmetic_unit.sv
// top level of the quaternion arithmetic unit: operand routing, pipeline control, four lanes
// depends on qau_pkg, qau_lane, qau_merge and quaternion_arithmetic_unit_defines.svh
//
// Takes one word per cycle while op_ready is high and gives one result word per word. A
// taken word moves through the stages in order, and its result is valid once it reaches
// the last stage. Sustained rate is one word per clock while res_ready is high; the
// five-stage pipeline (word products, sum and round, rotate products, final sum, clip
// and merge) is shared by all operations so results leave in order. Each pipeline stage
// loads whenever it is empty or the stage after it moves, so op_ready goes low only when
// all five stages hold words and res_ready is low. Multiply, rotate, conjugate, negate and
// dot share the four component lanes (rotate uses the three vector lanes, dot the w lane
// only); conjugate and negate go through the multipliers as a product with 1.0. Rotate
// needs the t vector of all three vector lanes, so t crosses between lanes after the second
// stage. No state is kept between words; reset only clears the stage valid bits.
`include "quaternion_arithmetic_unit_defines.svh"

module quaternion_arithmetic_unit import qau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     op_valid,
  output logic     op_ready,
  input  qau_op_t  op,
  output logic     res_valid,
  input  logic     res_ready,
  output qau_res_t res
);

  // stage valid bits and load enables; ld[STAGES+1] is the output side taking a word
  logic [STAGES:1]   v;
  logic [STAGES:1]   v_next;
  logic [STAGES+1:1] ld;

  // operand word carried alongside the lanes
  qau_op_t    w1;
  qau_op_t    w2;
  logic [2:0] kind3;

  qau_ctl_t   ctl;
  qau_ops1_t  ops1 [NUM_LANES];
  qau_ops3_t  ops3 [NUM_LANES];

  logic signed [VAL_BITS-1:0]         t [NUM_LANES];
  logic [NUM_LANES-1:0][FIN_BITS-1:0] fin;

  // ---------------------------------------------------------------- flow control
  always_comb begin
    ld[STAGES+1] = res_ready;
    for (int k = STAGES; k >= 1; k--) ld[k] = !v[k] || ld[k+1];
    v_next[1] = ld[1] ? op_valid : v[1];
    for (int k = 2; k <= STAGES; k++) v_next[k] = ld[k] ? v[k-1] : v[k];
  end

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else     v <= v_next;
  end

  assign op_ready  = ld[1];
  assign res_valid = v[STAGES];

  always_ff @(posedge clk) begin
    if (ld[1]) w1    <= op;
    if (ld[2]) w2    <= w1;
    if (ld[3]) kind3 <= w2.kind;
  end

  always_comb begin
    ctl.ld1  = ld[1];
    ctl.ld2  = ld[2];
    ctl.ld3  = ld[3];
    ctl.ld4  = ld[4];
    ctl.rot2 = (w1.kind == KIND_ROT);
    ctl.rot4 = (kind3 == KIND_ROT);
  end

  // ---------------------------------------------------------------- operand routing
  function automatic qau_ops1_t mk1(
    logic [WORD_BITS-1:0] m0a, logic [WORD_BITS-1:0] m0b,
    logic [WORD_BITS-1:0] m1a, logic [WORD_BITS-1:0] m1b,
    logic [WORD_BITS-1:0] m2a, logic [WORD_BITS-1:0] m2b,
    logic [WORD_BITS-1:0] m3a, logic [WORD_BITS-1:0] m3b,
    logic [NUM_TERMS-1:0] neg
  );
    qau_ops1_t o;
    o.ma[0] = m0a; o.mb[0] = m0b;
    o.ma[1] = m1a; o.mb[1] = m1b;
    o.ma[2] = m2a; o.mb[2] = m2b;
    o.ma[3] = m3a; o.mb[3] = m3b;
    o.neg   = neg;
    return o;
  endfunction

  function automatic qau_ops3_t mk3(
    logic [WORD_BITS-1:0] q0, logic [VAL_BITS-1:0] t0,
    logic [WORD_BITS-1:0] q1, logic [VAL_BITS-1:0] t1,
    logic [WORD_BITS-1:0] q2, logic [VAL_BITS-1:0] t2,
    logic [NUM_TERMS3-1:0] neg, logic [WORD_BITS-1:0] vec
  );
    qau_ops3_t o;
    o.qa[0] = q0; o.tb[0] = t0;
    o.qa[1] = q1; o.tb[1] = t1;
    o.qa[2] = q2; o.tb[2] = t2;
    o.neg   = neg;
    o.v     = vec;
    return o;
  endfunction

  // first pass: neg bit i negates product i
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) ops1[i] = '0;
    case (op.kind)
      KIND_MUL: begin
        ops1[LANE_X] = mk1(op.a_w, op.b_x, op.a_x, op.b_w, op.a_y, op.b_z, op.a_z, op.b_y,
                           4'b1000);
        ops1[LANE_Y] = mk1(op.a_w, op.b_y, op.a_x, op.b_z, op.a_y, op.b_w, op.a_z, op.b_x,
                           4'b0010);
        ops1[LANE_Z] = mk1(op.a_w, op.b_z, op.a_x, op.b_y, op.a_y, op.b_x, op.a_z, op.b_w,
                           4'b0100);
        ops1[LANE_W] = mk1(op.a_w, op.b_w, op.a_x, op.b_x, op.a_y, op.b_y, op.a_z, op.b_z,
                           4'b1110);
      end
      KIND_ROT: begin
        // cross product q x v; doubled in the second stage
        ops1[LANE_X] = mk1(op.a_y, op.b_z, op.a_z, op.b_y, '0, '0, '0, '0, 4'b0010);
        ops1[LANE_Y] = mk1(op.a_z, op.b_x, op.a_x, op.b_z, '0, '0, '0, '0, 4'b0010);
        ops1[LANE_Z] = mk1(op.a_x, op.b_y, op.a_y, op.b_x, '0, '0, '0, '0, 4'b0010);
      end
      KIND_CONJ: begin
        ops1[LANE_X] = mk1(op.a_x, ONE, '0, '0, '0, '0, '0, '0, 4'b0001);
        ops1[LANE_Y] = mk1(op.a_y, ONE, '0, '0, '0, '0, '0, '0, 4'b0001);
        ops1[LANE_Z] = mk1(op.a_z, ONE, '0, '0, '0, '0, '0, '0, 4'b0001);
        ops1[LANE_W] = mk1(op.a_w, ONE, '0, '0, '0, '0, '0, '0, 4'b0000);
      end
      KIND_NEG: begin
        ops1[LANE_X] = mk1(op.a_x, ONE, '0, '0, '0, '0, '0, '0, 4'b0001);
        ops1[LANE_Y] = mk1(op.a_y, ONE, '0, '0, '0, '0, '0, '0, 4'b0001);
        ops1[LANE_Z] = mk1(op.a_z, ONE, '0, '0, '0, '0, '0, '0, 4'b0001);
        ops1[LANE_W] = mk1(op.a_w, ONE, '0, '0, '0, '0, '0, '0, 4'b0001);
      end
      KIND_DOT: begin
        ops1[LANE_W] = mk1(op.a_x, op.b_x, op.a_y, op.b_y, op.a_z, op.b_z, op.a_w, op.b_w,
                           4'b0000);
      end
      default: begin
        // undefined kinds give an all-zero result
        for (int i = 0; i < NUM_LANES; i++) ops1[i] = '0;
      end
    endcase
  end

  // second pass, rotate only: w*t + q x t, with the vector component added before rounding
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) ops3[i] = '0;
    if (w2.kind == KIND_ROT) begin
      ops3[LANE_X] = mk3(w2.a_w, t[LANE_X], w2.a_y, t[LANE_Z], w2.a_z, t[LANE_Y],
                         3'b100, w2.b_x);
      ops3[LANE_Y] = mk3(w2.a_w, t[LANE_Y], w2.a_z, t[LANE_X], w2.a_x, t[LANE_Z],
                         3'b100, w2.b_y);
      ops3[LANE_Z] = mk3(w2.a_w, t[LANE_Z], w2.a_x, t[LANE_Y], w2.a_y, t[LANE_X],
                         3'b100, w2.b_z);
    end
  end

  // ---------------------------------------------------------------- lanes and merge
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    qau_lane u_lane (
      .clk  (clk),
      .ctl  (ctl),
      .ops1 (ops1[g]),
      .ops3 (ops3[g]),
      .t    (t[g]),
      .fin  (fin[g])
    );
  end

  qau_merge u_merge (
    .clk (clk),
    .ld  (ld[STAGES]),
    .fin (fin),
    .res (res)
  );

  // ---------------------------------------------------------------- checks
  // a taken word always lands in the first stage
  `QAU_ASSERT_NEXT(a_accept_lands, op_valid && op_ready, v[1], "accepted word not in stage 1")

  // words in flight never drop unless one leaves at the output
  `QAU_ASSERT_NEXT(a_no_loss,
    !(res_valid && res_ready) && !(op_valid && op_ready),
    $countones(v) == $past($countones(v)), "word count changed without a handshake")

  // a clip flag means some component sits at a word limit
  `QAU_ASSERT_IMPL(a_sat_limit, res_valid && res.saturated,
    res.out_x == WORD_MAX || res.out_x == WORD_MIN || res.out_y == WORD_MAX ||
    res.out_y == WORD_MIN || res.out_z == WORD_MAX || res.out_z == WORD_MIN ||
    res.out_w == WORD_MAX || res.out_w == WORD_MIN, "saturated set with no clipped component")

  // with every stage full and the output stalled, no new word is taken
  `QAU_ASSERT_IMPL(a_full_stall, (&v) && !res_ready, !op_ready,
    "ready high with a full stalled pipeline")

endmodule
